// File: src/acmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared types, constants and AES helper functions for the CMAC engine.
// ----------------------------------------------------------------------------
package acmac_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ROUND_W = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
    localparam logic [7:0] GF_POLY = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd16;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ZERO_RUN,
        ST_RUN,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic key_load;   // load round key 0 from the key registers
        logic start_zero; // load state with the zero block, key add
        logic start_blk;  // load state with chain xor block, key add
        logic round;      // perform one round and step the round key
        logic take_l;     // derive subkeys from state
        logic save_chain; // store state into the chain
        logic clear_chain;
    } cmd_t;

    typedef struct packed {
        logic final_round; // current round is the last one
    } stat_t;

    localparam logic [7:0] SBOX [256] = '{
     8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
     8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
     8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
     8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
     8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
     8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
     8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
     8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
     8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
     8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
     8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
     8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
     8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
     8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
     8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
     8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i of a block sits in bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(block_t b, int unsigned i);
        get_byte = b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon_of(logic [ROUND_W-1:0] r);
        unique case (r)
            4'd1:    rcon_of = 8'h01;
            4'd2:    rcon_of = 8'h02;
            4'd3:    rcon_of = 8'h04;
            4'd4:    rcon_of = 8'h08;
            4'd5:    rcon_of = 8'h10;
            4'd6:    rcon_of = 8'h20;
            4'd7:    rcon_of = 8'h40;
            4'd8:    rcon_of = 8'h80;
            4'd9:    rcon_of = 8'h1b;
            4'd10:   rcon_of = 8'h36;
            default: rcon_of = 8'h00;
        endcase
    endfunction

    // next round key from the previous one
    function automatic block_t next_key(block_t p, logic [ROUND_W-1:0] r);
        logic [7:0] k [16];
        logic [7:0] t [4];
        block_t res;
        t[0] = SBOX[get_byte(p, 13)] ^ rcon_of(r);
        t[1] = SBOX[get_byte(p, 14)];
        t[2] = SBOX[get_byte(p, 15)];
        t[3] = SBOX[get_byte(p, 12)];
        for (int j = 0; j < 4; j++) k[j] = get_byte(p, j) ^ t[j];
        for (int j = 4; j < 16; j++) k[j] = get_byte(p, j) ^ k[j-4];
        for (int j = 0; j < 16; j++) res[BLOCK_W-1-8*j -: 8] = k[j];
        return res;
    endfunction

    // one AES round without the key add; mix skipped on the last round
    function automatic block_t round_fn(block_t s, logic do_mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        block_t res;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[c*4+i] = SBOX[get_byte(s, ((c + i) % 4) * 4 + i)];
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                x = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int j = 0; j < 16; j++) res[BLOCK_W-1-8*j -: 8] = t[j];
        return res;
    endfunction

    function automatic block_t gf_double(block_t v);
        gf_double = {v[BLOCK_W-2:0], 1'b0} ^ {{(BLOCK_W-8){1'b0}}, (v[BLOCK_W-1] ? GF_POLY : 8'h00)};
    endfunction

endpackage

// File: src/acmac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_in_if / acmac_out_if
// Valid/ready channels for message blocks and tags.
// ----------------------------------------------------------------------------
interface acmac_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        last;
    modport source (output valid, data_high, data_low, byte_count, last, input ready);
    modport sink   (input valid, data_high, data_low, byte_count, last, output ready);
endinterface

interface acmac_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    modport source (output valid, tag_high, tag_low, input ready);
    modport sink   (input valid, tag_high, tag_low, output ready);
endinterface

// File: src/acmac_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_datapath
// AES round unit with on-the-fly key schedule, chain and subkey registers.
// ----------------------------------------------------------------------------
module acmac_datapath (
    input  logic                    clk,
    input  acmac_pkg::cmd_t         cmd,
    output acmac_pkg::stat_t        stat,
    input  logic [127:0]            key,
    input  logic [127:0]            blk_data,
    input  logic [4:0]              byte_count,
    input  logic                    last,
    output logic [127:0]            result
);
    import acmac_pkg::*;

    block_t state_reg, state_next;
    block_t rkey_reg, rkey_next;
    block_t key0_reg;
    block_t chain_reg, k1_reg, k2_reg;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    block_t msg_blk, padded, mask;
    logic [COUNT_W-1:0] n;

    // last-block padding and subkey xor
    always_comb
    begin
        n = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
        mask = '0;
        padded = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < n) mask[BLOCK_W-1-8*i -: 8] = 8'hff;
            if (i == n) padded[BLOCK_W-1-8*i -: 8] = PAD_BYTE;
        end
        if (!last)
            msg_blk = blk_data;
        else if (n == FULL_COUNT)
            msg_blk = blk_data ^ k1_reg;
        else
            msg_blk = ((blk_data & mask) | padded) ^ k2_reg;
    end

    // round sequencing
    always_comb
    begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rnd_next   = rnd_reg;
        if (cmd.start_zero) begin
            state_next = key0_reg;
            rkey_next  = key0_reg;
            rnd_next   = '0;
        end else if (cmd.start_blk) begin
            state_next = chain_reg ^ msg_blk ^ key0_reg;
            rkey_next  = key0_reg;
            rnd_next   = '0;
        end else if (cmd.round) begin
            rnd_next   = rnd_reg + 1'b1;
            rkey_next  = next_key(rkey_reg, rnd_reg + 1'b1);
            state_next = round_fn(state_reg, (rnd_reg + 1'b1) != LAST_ROUND) ^ rkey_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rnd_reg   <= rnd_next;
        if (cmd.key_load) key0_reg <= key;
        if (cmd.take_l) begin
            k1_reg <= gf_double(state_reg);
            k2_reg <= gf_double(gf_double(state_reg));
        end
        if (cmd.clear_chain) chain_reg <= '0;
        else if (cmd.save_chain) chain_reg <= state_reg;
    end

    assign stat.final_round = (rnd_reg == LAST_ROUND);
    assign result = state_reg;
endmodule

// File: src/acmac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmac_ctrl
// Sequencer for subkey setup, block encryption and tag delivery.
// ----------------------------------------------------------------------------
module acmac_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output acmac_pkg::cmd_t  cmd,
    input  acmac_pkg::stat_t stat
);
    import acmac_pkg::*;

    state_t state_reg, state_next;
    logic   in_msg_reg, in_msg_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            in_msg_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            in_msg_reg <= in_msg_next;
            last_reg   <= last_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_msg_next = in_msg_reg;
        last_next   = last_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!in_msg_reg) begin
                    // key is sampled when the first block of a message shows up
                    if (in_valid) begin
                        cmd.key_load    = 1'b1;
                        cmd.clear_chain = 1'b1;
                        state_next      = ST_INIT;
                    end
                end else begin
                    in_ready = 1'b1;
                    if (in_valid) begin
                        cmd.start_blk = 1'b1;
                        last_next     = in_last;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_INIT: begin
                cmd.start_zero = 1'b1;
                state_next     = ST_ZERO_RUN;
            end
            ST_ZERO_RUN: begin
                if (stat.final_round) begin
                    cmd.take_l  = 1'b1;
                    in_msg_next = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.round = 1'b1;
                end
            end
            ST_RUN: begin
                if (stat.final_round) begin
                    if (last_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.save_chain = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd.round = 1'b1;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    in_msg_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> in_msg_reg) else $error("ready outside message");
    a_no_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while tag pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("tag dropped");
`endif
endmodule

// File: src/aes_cmac_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cmac_stream_unit
// AES-128 CMAC engine, one 16-byte block per transfer.
// ----------------------------------------------------------------------------
//  channel   dir   content
//  blk_in    in    data_high, data_low, byte_count, last
//  tag_out   out   tag_high, tag_low
//  cfg       in    cfg_we, cfg_index, cfg_data (key_high, key_low)
//
// Each block takes a load/key-add step and ten rounds in the single round
// unit, plus a return to idle. The first block of a message also needs an
// encryption of zero for the subkeys. The tag is held until taken; no
// block is accepted while it waits. Reset clears control.
// ----------------------------------------------------------------------------
module aes_cmac_stream_unit (
    input  logic         clk,
    input  logic         rst_n,
    acmac_in_if.sink     blk_in,
    acmac_out_if.source  tag_out,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);
    import acmac_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    cmd_t   cmd;
    stat_t  stat;
    block_t result;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    acmac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (blk_in.valid),
        .in_ready  (blk_in.ready),
        .in_last   (blk_in.last),
        .out_valid (tag_out.valid),
        .out_ready (tag_out.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    acmac_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .key        ({key_high_reg, key_low_reg}),
        .blk_data   ({blk_in.data_high, blk_in.data_low}),
        .byte_count (blk_in.byte_count),
        .last       (blk_in.last),
        .result     (result)
    );

    assign tag_out.tag_high = result[127:64];
    assign tag_out.tag_low  = result[63:0];
endmodule
